FILE: rtl/mavg_pkg.sv
package mavg_pkg;

    // Datapath sizes.
    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_MAX  = 64;
    localparam int CFG_BITS    = 7;
    localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
    localparam int W_BITS      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS;
    localparam int REM_BITS    = W_BITS + 1;
    localparam int CNT_BITS    = $clog2(SUM_BITS + 1);

    // Job queue between the front end and the divider.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // One pending average: the window sum and the divisor that goes with it.
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic        [W_BITS-1:0]   w;
    } t_job;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_OUT
    } t_back_state;

    // A window length of zero acts as one, and anything above the delay line depth
    // acts as the full depth.
    function automatic logic [W_BITS-1:0] effective_window(input logic [CFG_BITS-1:0] v);
        logic [W_BITS-1:0] w;
        if (v == '0) begin
            w = W_BITS'(1);
        end else if (int'(v) > WINDOW_MAX) begin
            w = W_BITS'(WINDOW_MAX);
        end else begin
            w = W_BITS'(v);
        end
        return w;
    endfunction

endpackage

FILE: rtl/moving_average_filter.sv
// Each sample goes through a delay line read, then the sum update; a full job queue holds
// the update and so the input. Averages come one at a time from the bit-serial divider
// (load, 22 steps, output load), which takes no new job until the last is in its output register.
// A two-entry job queue lets warm-up samples and the divider overlap.
// Reset (synchronous, active low) clears the sum, fill count, write pointer, queue and
// output valid, and sets the window length to 1; the delay line is not cleared.
module moving_average_filter
    import mavg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_of_set,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_BITS-1:0]           i_cfg_window_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    logic push;
    logic queue_full;
    t_job push_job;
    logic pop;
    logic job_valid;
    t_job job;

    // The window length register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Front end: delay line and running sum.
    mavg_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample            (i_sample),
        .i_start_of_set      (i_start_of_set),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_window_length (i_cfg_window_length),
        .i_queue_full        (queue_full),
        .o_push              (push),
        .o_job               (push_job)
    );

    // Pending averages between the two halves.
    mavg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job)
    );

    // Back end: rounded division and the output register.
    mavg_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_average   (o_average)
    );

endmodule

FILE: rtl/mavg_ram.sv
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port, registered read port; the read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mavg_queue.sv
module mavg_queue
    import mavg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr;
    logic [QPTR_BITS-1:0] n_rd;
    logic [QCNT_BITS-1:0] n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // The occupancy never goes past the number of entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule

FILE: rtl/mavg_front.sv
module mavg_front
    import mavg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_of_set,
    input  logic                          i_cfg_valid,
    input  logic [CFG_BITS-1:0]           i_cfg_window_length,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output t_job                          o_job
);

    t_front_state               r_state;
    t_front_state               n_state;
    logic signed [SUM_BITS-1:0] r_sum;
    logic signed [SUM_BITS-1:0] n_sum;
    logic [W_BITS-1:0]          r_fill;
    logic [W_BITS-1:0]          n_fill;
    logic [ADDR_BITS-1:0]       r_wp;
    logic [ADDR_BITS-1:0]       n_wp;
    logic [W_BITS-1:0]          r_w;
    logic [W_BITS-1:0]          n_w;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_start;

    logic [W_BITS-1:0]          wp_ext;
    logic [W_BITS-1:0]          old_idx;
    logic [ADDR_BITS-1:0]       old_addr;
    logic                       rd_en;
    logic                       wr_en;
    logic [SAMPLE_BITS-1:0]     old_data;
    logic signed [SUM_BITS-1:0] base_sum;
    logic [W_BITS-1:0]          base_fill;
    logic signed [SUM_BITS-1:0] upd_sum;
    logic [W_BITS-1:0]          upd_fill;
    logic                       full_window;
    logic                       emit;

    // Delay line entry that leaves the window: W places behind the write pointer.
    always_comb begin
        wp_ext = W_BITS'(r_wp);
        if (wp_ext >= r_w) begin
            old_idx = wp_ext - r_w;
        end else begin
            old_idx = wp_ext + W_BITS'(WINDOW_MAX) - r_w;
        end
        old_addr = old_idx[ADDR_BITS-1:0];
    end

    mavg_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(WINDOW_MAX)
    ) u_delay (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (r_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (old_addr),
        .o_rd_data (old_data)
    );

    // Running sum update for the sample held in the staging register.
    always_comb begin
        base_sum    = r_start ? '0 : r_sum;
        base_fill   = r_start ? '0 : r_fill;
        full_window = (base_fill >= r_w);
        if (full_window) begin
            upd_sum  = base_sum + SUM_BITS'(r_sample) - SUM_BITS'($signed(old_data));
            upd_fill = base_fill;
        end else begin
            upd_sum  = base_sum + SUM_BITS'(r_sample);
            upd_fill = base_fill + 1'b1;
        end
        emit = (upd_fill >= r_w);
    end

    assign o_job.sum = upd_sum;
    assign o_job.w   = r_w;
    assign o_ready   = (r_state == F_IDLE);

    // Sequencer: take a sample and read the leaving entry, then commit the update.
    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_fill  = r_fill;
        n_wp    = r_wp;
        n_w     = r_w;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                rd_en = i_valid;
                if (i_valid) begin
                    n_state = F_UPD;
                end
            end
            F_UPD: begin
                if (!(emit && i_queue_full)) begin
                    wr_en   = 1'b1;
                    o_push  = emit;
                    n_sum   = upd_sum;
                    n_fill  = upd_fill;
                    n_wp    = (r_wp == ADDR_BITS'(WINDOW_MAX - 1)) ? '0 : r_wp + 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
        // A new window length restarts the data set.
        if (i_cfg_valid) begin
            n_w    = effective_window(i_cfg_window_length);
            n_fill = '0;
            n_sum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_sum   <= '0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_w     <= W_BITS'(1);
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_fill  <= n_fill;
            r_wp    <= n_wp;
            r_w     <= n_w;
        end
    end

    // The incoming sample is staged while its update is pending.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= i_sample;
            r_start  <= i_start_of_set;
        end
    end

    // The fill count saturates at the window length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_w)
        else $error("fill count exceeds window length");

    // An update blocked by a full queue leaves the sum and pointer untouched.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_UPD && emit && i_queue_full && !i_cfg_valid)
        |=> (r_state == F_UPD && $stable(r_sum) && $stable(r_wp)))
        else $error("blocked update changed the window state");

endmodule

FILE: rtl/mavg_divider.sv
module mavg_divider
    import mavg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  t_job                          i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    t_back_state                   r_state;
    t_back_state                   n_state;
    logic [SUM_BITS-1:0]           r_dividend;
    logic [SUM_BITS-1:0]           n_dividend;
    logic [REM_BITS-1:0]           r_rem;
    logic [REM_BITS-1:0]           n_rem;
    logic [W_BITS-1:0]             r_w;
    logic [W_BITS-1:0]             n_w;
    logic                          r_neg;
    logic                          n_neg;
    logic [CNT_BITS-1:0]           r_count;
    logic [CNT_BITS-1:0]           n_count;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_average;
    logic signed [SAMPLE_BITS-1:0] n_average;

    logic [SUM_BITS-1:0]           job_mag;
    logic [REM_BITS-1:0]           shifted;
    logic                          q_bit;
    logic [SUM_BITS-1:0]           quotient;

    // Rounded magnitude: |sum| plus half the divisor, ties go away from zero.
    always_comb begin
        if (i_job.sum < 0) begin
            job_mag = SUM_BITS'(-i_job.sum);
        end else begin
            job_mag = SUM_BITS'(i_job.sum);
        end
        job_mag = job_mag + SUM_BITS'(i_job.w >> 1);
    end

    // One restoring division step per cycle.
    always_comb begin
        shifted = {r_rem[REM_BITS-2:0], r_dividend[SUM_BITS-1]};
        q_bit   = (shifted >= {1'b0, r_w});
    end

    assign quotient = r_neg ? (SUM_BITS'(0) - r_dividend) : r_dividend;

    assign o_valid   = r_out_valid;
    assign o_average = r_average;

    always_comb begin
        n_state     = r_state;
        n_dividend  = r_dividend;
        n_rem       = r_rem;
        n_w         = r_w;
        n_neg       = r_neg;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_average   = r_average;
        o_pop       = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_pop      = 1'b1;
                    n_dividend = job_mag;
                    n_rem      = '0;
                    n_w        = i_job.w;
                    n_neg      = (i_job.sum < 0);
                    n_count    = CNT_BITS'(SUM_BITS);
                    n_state    = B_DIV;
                end
            end
            B_DIV: begin
                n_rem      = q_bit ? (shifted - {1'b0, r_w}) : shifted;
                n_dividend = {r_dividend[SUM_BITS-2:0], q_bit};
                n_count    = r_count - 1'b1;
                if (r_count == CNT_BITS'(1)) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                // The dividend register now holds the quotient.
                if (!r_out_valid || i_ready) begin
                    n_average   = quotient[SAMPLE_BITS-1:0];
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
        r_w        <= n_w;
        r_neg      <= n_neg;
        r_average  <= n_average;
    end

    // The partial remainder stays below the divisor throughout the division.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_rem < {1'b0, r_w}))
        else $error("partial remainder not below divisor");

    // Each division cycle retires one quotient bit until the count runs out.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && r_count != CNT_BITS'(1))
        |=> (r_state == B_DIV && r_count == $past(r_count) - 1'b1))
        else $error("division step count broken");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import mavg_pkg::*;
();

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;

    // Kinds of rows in the directed script.
    typedef enum logic {
        ROW_WINDOW,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;
        logic        sos;
        logic        known;
        logic [31:0] want;
    } t_script_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_start_of_set;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_BITS-1:0]           i_cfg_window_length;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [SAMPLE_BITS-1:0] o_average;

    moving_average_filter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample            (i_sample),
        .i_start_of_set      (i_start_of_set),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_length (i_cfg_window_length),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_average           (o_average)
    );

    // Predicted filter state, kept alongside the block.
    logic [CFG_BITS-1:0]           win_setting;
    int                            tap_line [WINDOW_MAX];
    int                            tap_sum;
    int                            tap_count;
    int                            tap_wp;

    logic signed [SAMPLE_BITS-1:0] averages_due [$];
    logic signed [SAMPLE_BITS-1:0] want_avg;
    t_script_row                   script [$];
    int                            fail_count;
    int                            cycle_count;
    int                            rx_hold_cycles;
    bit                            tx_idle_on;
    bit                            rx_idle_on;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    // A setting of zero behaves as one; anything beyond the delay line depth as the full depth.
    function automatic int span_of(input logic [CFG_BITS-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(v);
    endfunction

    // A window write restarts the fill and the running sum.
    function automatic void window_write(input logic [CFG_BITS-1:0] v);
        win_setting = v;
        tap_sum     = 0;
        tap_count   = 0;
    endfunction

    // Takes one sample into the predicted window; returns 1 when an average is due.
    function automatic bit predict_average(input logic signed [SAMPLE_BITS-1:0] x,
                                           input logic sos,
                                           output logic signed [SAMPLE_BITS-1:0] avg);
        int w;
        int mag;
        int q;
        w = span_of(win_setting);
        if (sos) begin
            tap_sum   = 0;
            tap_count = 0;
        end
        tap_sum = tap_sum + int'(x);
        if (tap_count >= w) begin
            tap_sum = tap_sum - tap_line[(tap_wp + WINDOW_MAX - w) % WINDOW_MAX];
        end else begin
            tap_count++;
        end
        tap_line[tap_wp] = int'(x);
        tap_wp = (tap_wp + 1) % WINDOW_MAX;
        avg = '0;
        if (tap_count < w) begin
            return 1'b0;
        end
        // Round half away from zero on the magnitude.
        mag = (tap_sum < 0) ? -tap_sum : tap_sum;
        q   = (mag + w / 2) / w;
        avg = SAMPLE_BITS'((tap_sum < 0) ? -q : q);
        return 1'b1;
    endfunction

    function automatic void add_sample(input int value, input bit sos, input bit known,
                                       input int want);
        script.push_back('{ROW_SAMPLE, 32'(value), sos, known, 32'(want)});
    endfunction

    function automatic void add_window(input int value);
        script.push_back('{ROW_WINDOW, 32'(value), 1'b0, 1'b0, 32'd0});
    endfunction

    // Offers one sample transaction, with random gaps ahead of it, and predicts its result.
    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic sos,
                                input logic known, input logic signed [SAMPLE_BITS-1:0] want);
        logic signed [SAMPLE_BITS-1:0] avg;
        while (tx_idle_on && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample       <= s;
        i_start_of_set <= sos;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        if (predict_average(s, sos, avg)) begin
            averages_due.push_back(known ? want : avg);
        end
        @(negedge i_clk);
    endtask

    // Writes the window length once the block has drained.
    task automatic set_window(input logic [CFG_BITS-1:0] v);
        i_valid <= 1'b0;
        while (averages_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_window_length <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        window_write(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver stalls at random, or for a long stretch when asked to hold off.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(rx_idle_on && $urandom_range(0, 99) < 13);
            end
        end
    end

    // Each accepted average is compared with the oldest predicted one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (averages_due.size() == 0) begin
                $error("average: unexpected transaction, actual %0d", o_average);
                fail_count++;
            end else begin
                want_avg = averages_due.pop_front();
                if (o_average !== want_avg) begin
                    $error("average mismatch: expected %0d, actual %0d", want_avg, o_average);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int                            n;
        int                            len;
        int                            w;
        logic [CFG_BITS-1:0]           cfg;
        logic                          sos;
        logic signed [SAMPLE_BITS-1:0] s;

        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_sample            = '0;
        i_start_of_set      = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_window_length = '0;
        fail_count          = 0;
        cycle_count         = 0;
        rx_hold_cycles      = 0;
        tx_idle_on          = 1'b1;
        rx_idle_on          = 1'b1;
        window_write(CFG_BITS'(1));
        tap_wp              = 0;
        foreach (tap_line[i]) begin
            tap_line[i] = 0;
        end

        // With the reset window of one, every average is the sample itself.
        add_sample(-32768, 1'b1, 1'b1, -32768);
        add_sample(32767, 1'b0, 1'b1, 32767);
        add_sample(0, 1'b0, 1'b1, 0);
        add_sample(-1, 1'b1, 1'b1, -1);
        add_sample(1, 1'b0, 1'b1, 1);
        // A window of two: warm-up, ties rounded away from zero, full-scale sums.
        add_window(2);
        add_sample(1, 1'b1, 1'b0, 0);
        add_sample(0, 1'b0, 1'b1, 1);
        add_sample(-1, 1'b1, 1'b0, 0);
        add_sample(0, 1'b0, 1'b1, -1);
        add_sample(32767, 1'b1, 1'b0, 0);
        add_sample(32767, 1'b0, 1'b1, 32767);
        add_sample(-32768, 1'b0, 1'b0, 0);
        add_sample(-32768, 1'b0, 1'b1, -32768);
        // A zero window behaves as a window of one.
        add_window(0);
        add_sample(12345, 1'b1, 1'b1, 12345);
        add_sample(-7, 1'b0, 1'b1, -7);
        // A window of three, restarted by a new set partway through.
        add_window(3);
        add_sample(1, 1'b1, 1'b0, 0);
        add_sample(1, 1'b0, 1'b0, 0);
        add_sample(0, 1'b0, 1'b0, 0);
        add_sample(5, 1'b1, 1'b0, 0);
        add_sample(6, 1'b0, 1'b0, 0);
        add_sample(7, 1'b0, 1'b0, 0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_WINDOW) begin
                set_window(CFG_BITS'(script[r].value));
            end else begin
                offer_sample(SAMPLE_BITS'(script[r].value), script[r].sos, script[r].known,
                             SAMPLE_BITS'(script[r].want));
            end
        end

        // Random phases, each under its own window setting.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    cfg = CFG_BITS'(127);
                end
                1: begin
                    cfg = CFG_BITS'(WINDOW_MAX);
                end
                2: begin
                    cfg = CFG_BITS'(1);
                end
                5: begin
                    cfg = CFG_BITS'(4);
                end
                default: begin
                    cfg = CFG_BITS'($urandom_range(0, 127));
                end
            endcase
            set_window(cfg);
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 3);
            // Hold the receiver off so the job queue fills and the input stalls.
            if (p == 5) begin
                rx_hold_cycles = HOLD_CYCLES;
            end
            w = span_of(cfg);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                // Mostly complete windows; now and then a set no longer than the window, which may not fill.
                if ($urandom_range(0, 99) < 80) begin
                    len = w + $urandom_range(0, 24);
                end else begin
                    len = $urandom_range(1, w);
                end
                for (int k = 0; k < len; k++) begin
                    if (k == 0) begin
                        sos = (n == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
                    end else begin
                        sos = ($urandom_range(0, 99) < 2);
                    end
                    case ($urandom_range(0, 9))
                        0: begin
                            s = 16'sh8000;
                        end
                        1: begin
                            s = 16'sh7FFF;
                        end
                        2: begin
                            s = SAMPLE_BITS'($urandom_range(0, 8)) - 16'sd4;
                        end
                        default: begin
                            s = SAMPLE_BITS'($urandom);
                        end
                    endcase
                    offer_sample(s, sos, 1'b0, '0);
                    n++;
                end
            end
        end

        // Drain the remaining averages, then allow the pipeline to settle.
        i_valid <= 1'b0;
        while (averages_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
